/* rtl/core/lcse_pkg.sv */
// ============================================================================
// lcse_pkg: shared types and constants for the LED color store SPI encoder
// Holds the command format passed between front and back, the SPI code
// bytes and the byte encoder used to expand one color byte.
// ============================================================================
`default_nettype none

package lcse_pkg;

    // Store size and field widths
    localparam int MAX_LED_COUNT = 8;
    localparam int IDX_W         = 3;
    localparam int COUNT_W       = 4;
    localparam int COLOR_W       = 24;
    localparam int WORD_W        = 64;
    localparam int ADDR_W        = 3;
    localparam int DATA_W        = 32;

    // Register map: word index taken from paddr[2]
    localparam logic REG_LED_COUNT = 1'b0;

    // Reset value of the LED count register
    localparam logic [COUNT_W-1:0] LED_COUNT_RESET = COUNT_W'(MAX_LED_COUNT);

    // SPI code bytes
    localparam logic [7:0] CODE_ZERO = 8'h70;
    localparam logic [7:0] CODE_ONE  = 8'h7C;
    localparam logic [7:0] TOP_BIT   = 8'h80;

    // One frame request handed from the front to the back
    typedef struct packed {
        logic                 write_en;
        logic [IDX_W-1:0]     idx;
        logic [COLOR_W-1:0]   color;
        logic [COUNT_W-1:0]   count;
    } cmd_t;

    // Clamp the programmed count to the store size
    function automatic logic [COUNT_W-1:0] clamp_count(input logic [COUNT_W-1:0] count);
        logic [COUNT_W-1:0] res;
        res = (count > COUNT_W'(MAX_LED_COUNT)) ? COUNT_W'(MAX_LED_COUNT) : count;
        return res;
    endfunction

    // Expand one color byte, MSB first, into eight SPI code bytes
    function automatic logic [WORD_W-1:0] encode_byte(input logic [7:0] value);
        logic [WORD_W-1:0] word;
        word = '0;
        for (int i = 0; i < 8; i++)
        begin
            word[WORD_W-1-8*i -: 8] = ((value & (TOP_BIT >> i)) != 8'h00) ? CODE_ONE
                                                                             : CODE_ZERO;
        end
        return word;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/lcse_front.sv */
// ============================================================================
// lcse_front: input side of the LED color store SPI encoder
// Accepts color writes, decides whether the write lands in the store and
// queues the resulting frame request in a two-entry command queue.
// ============================================================================
`default_nettype none

module lcse_front (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          push,
    output logic                               full,
    input  wire logic [lcse_pkg::IDX_W-1:0]    led_index,
    input  wire logic [7:0]                    green_value,
    input  wire logic [7:0]                    red_value,
    input  wire logic [7:0]                    blue_value,
    input  wire logic [lcse_pkg::COUNT_W-1:0]  led_count,
    output logic                               cmd_valid,
    output lcse_pkg::cmd_t                     cmd,
    input  wire logic                          cmd_pop
);
    import lcse_pkg::*;

    cmd_t        queue_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  fill_reg;
    logic        do_push;
    logic        do_pop;
    cmd_t        new_cmd;
    logic [COUNT_W-1:0] eff_count;

    // Classify the incoming transaction
    always_comb
    begin
        eff_count        = clamp_count(led_count);
        new_cmd.write_en = ({1'b0, led_index} < eff_count);
        new_cmd.idx      = led_index;
        new_cmd.color    = {green_value, red_value, blue_value};
        new_cmd.count    = eff_count;
    end

    assign full      = (fill_reg == 2'd2);
    assign cmd_valid = (fill_reg != 2'd0);
    assign cmd       = queue_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = cmd_pop && cmd_valid;

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            queue_reg[wr_ptr_reg] <= new_cmd;
        end
    end

    // Queue pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (do_push && !do_pop)
            begin
                fill_reg <= fill_reg + 2'd1;
            end
            else if (do_pop && !do_push)
            begin
                fill_reg <= fill_reg - 2'd1;
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/core/lcse_back.sv */
// ============================================================================
// lcse_back: color store and frame sequencer
// Applies a queued color write to the store, then walks the LEDs in green,
// red, blue order and emits one encoded SPI word per color byte.
// ============================================================================
`default_nettype none

module lcse_back (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cmd_valid,
    input  wire lcse_pkg::cmd_t               cmd,
    output logic                              cmd_pop,
    input  wire logic                         pop,
    output logic                              empty,
    output logic [lcse_pkg::WORD_W-1:0]       spi_word,
    output logic                              frame_end
);
    import lcse_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } state_t;

    localparam logic [1:0] COLOR_GREEN = 2'd0;
    localparam logic [1:0] COLOR_RED   = 2'd1;
    localparam logic [1:0] COLOR_BLUE  = 2'd2;

    state_t              state_reg;
    logic [IDX_W-1:0]    led_reg;
    logic [1:0]          color_reg;
    logic [COUNT_W-1:0]  count_reg;
    logic                out_valid_reg;
    logic [WORD_W-1:0]   spi_word_reg;
    logic                frame_end_reg;
    logic [COLOR_W-1:0]  store_reg [MAX_LED_COUNT];

    logic [COLOR_W-1:0]  entry;
    logic [7:0]          sel_byte;
    logic                out_free;
    logic                last_led;
    logic                last_color;

    assign out_free   = !out_valid_reg || pop;
    assign cmd_pop    = (state_reg == ST_IDLE) && cmd_valid;
    assign empty      = !out_valid_reg;
    assign spi_word   = spi_word_reg;
    assign frame_end  = frame_end_reg;
    assign last_led   = ({1'b0, led_reg} == (count_reg - COUNT_W'(1)));
    assign last_color = (color_reg == COLOR_BLUE);
    assign entry      = store_reg[led_reg];

    // Pick the color byte for the current word
    always_comb
    begin
        case (color_reg)
            COLOR_GREEN: sel_byte = entry[23:16];
            COLOR_RED:   sel_byte = entry[15:8];
            COLOR_BLUE:  sel_byte = entry[7:0];
            default:     sel_byte = 8'h00;
        endcase
    end

    // Color store, cleared at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_LED_COUNT; i++)
            begin
                store_reg[i] <= '0;
            end
        end
        else if (cmd_pop && cmd.write_en)
        begin
            store_reg[cmd.idx] <= cmd.color;
        end
    end

    // Sequencer and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            led_reg       <= '0;
            color_reg     <= COLOR_GREEN;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            spi_word_reg  <= '0;
            frame_end_reg <= 1'b0;
        end
        else
        begin
            // Output valid: loaded by a new word, cleared when taken
            if ((state_reg == ST_EMIT) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop && out_valid_reg)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        count_reg <= cmd.count;
                        led_reg   <= '0;
                        color_reg <= COLOR_GREEN;
                        if (cmd.count != '0)
                        begin
                            state_reg <= ST_EMIT;
                        end
                    end
                end
                ST_EMIT:
                begin
                    if (out_free)
                    begin
                        spi_word_reg  <= encode_byte(sel_byte);
                        frame_end_reg <= last_led && last_color;
                        if (last_color)
                        begin
                            color_reg <= COLOR_GREEN;
                            if (last_led)
                            begin
                                state_reg <= ST_IDLE;
                            end
                            else
                            begin
                                led_reg <= led_reg + IDX_W'(1);
                            end
                        end
                        else
                        begin
                            color_reg <= color_reg + 2'd1;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

/* rtl/core/led_color_store_spi_encoder_core.sv */
// ============================================================================
// led_color_store_spi_encoder_core: LED color store with SPI bit encoding
// Top level: configuration register, front queue and back sequencer.
// ============================================================================
// Each pushed transaction writes one LED's green/red/blue color (ignored when
// led_index is at or above the effective LED count) and then emits the whole
// frame: three 64-bit words per LED, green, red, blue, each color byte
// expanded MSB first into 0x7C (one) / 0x70 (zero) code bytes, first byte in
// bits 63..56, frame_end set on the last word. led_count above 8 acts as 8;
// a count of 0 produces no words. The back sequencer applies the write in its
// idle state and then emits one word per cycle while pop keeps up; that
// sequencer sets the rate. A two-entry command queue lets up to two further
// transactions be pushed while a frame is being emitted.
`default_nettype none

module led_color_store_spi_encoder_core (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // Input queue side
    input  wire logic                          push,
    output logic                               full,
    input  wire logic [lcse_pkg::IDX_W-1:0]    led_index,
    input  wire logic [7:0]                    green_value,
    input  wire logic [7:0]                    red_value,
    input  wire logic [7:0]                    blue_value,
    // Result queue side
    output logic                               empty,
    input  wire logic                          pop,
    output logic [lcse_pkg::WORD_W-1:0]        spi_word,
    output logic                               frame_end,
    // Configuration port
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [lcse_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [lcse_pkg::DATA_W-1:0]   pwdata,
    output logic [lcse_pkg::DATA_W-1:0]        prdata,
    output logic                               pready
);
    import lcse_pkg::*;

    logic [COUNT_W-1:0] led_count_reg;
    logic               cfg_write;
    logic               cmd_valid;
    cmd_t               cmd;
    logic               cmd_pop;

    // Configuration register
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            led_count_reg <= LED_COUNT_RESET;
        end
        else if (cfg_write && (paddr[2] == REG_LED_COUNT))
        begin
            led_count_reg <= pwdata[COUNT_W-1:0];
        end
    end

    // Register readback
    assign prdata = (paddr[2] == REG_LED_COUNT) ? DATA_W'(led_count_reg) : '0;

    lcse_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .led_index   (led_index),
        .green_value (green_value),
        .red_value   (red_value),
        .blue_value  (blue_value),
        .led_count   (led_count_reg),
        .cmd_valid   (cmd_valid),
        .cmd         (cmd),
        .cmd_pop     (cmd_pop)
    );

    lcse_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .pop       (pop),
        .empty     (empty),
        .spi_word  (spi_word),
        .frame_end (frame_end)
    );

endmodule

`default_nettype wire

/* rtl/core/lcse_checker.sv */
// ============================================================================
// lcse_checker: port-level checks for the LED color store SPI encoder
// Tracks the LED count from configuration writes and checks frame length,
// word coding and result hold behavior.
// ============================================================================
`default_nettype none

module lcse_checker (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [lcse_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [lcse_pkg::DATA_W-1:0]   pwdata,
    input  wire logic                          pready,
    input  wire logic                          empty,
    input  wire logic                          pop,
    input  wire logic [lcse_pkg::WORD_W-1:0]   spi_word,
    input  wire logic                          frame_end
);
    import lcse_pkg::*;

    logic [COUNT_W-1:0] eff_count_reg;
    logic [4:0]         word_cnt_reg;
    logic [4:0]         frame_len;
    logic               all_codes;
    logic               out_take;

    assign out_take  = pop && !empty;
    assign frame_len = 5'(eff_count_reg) + 5'(eff_count_reg) + 5'(eff_count_reg);

    // Every byte of a shown word is a valid code byte
    always_comb
    begin
        all_codes = 1'b1;
        for (int i = 0; i < 8; i++)
        begin
            if ((spi_word[8*i +: 8] != CODE_ONE) && (spi_word[8*i +: 8] != CODE_ZERO))
            begin
                all_codes = 1'b0;
            end
        end
    end

    // Shadow of the effective LED count and words taken in this frame
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eff_count_reg <= LED_COUNT_RESET;
            word_cnt_reg  <= '0;
        end
        else
        begin
            if (psel && penable && pwrite && pready && (paddr[2] == REG_LED_COUNT))
            begin
                eff_count_reg <= clamp_count(pwdata[COUNT_W-1:0]);
            end
            if (out_take)
            begin
                word_cnt_reg <= frame_end ? 5'd0 : word_cnt_reg + 5'd1;
            end
        end
    end

    // Nothing is waiting in the first cycle out of reset
    a_reset_empty: assert property (@(posedge clk) $rose(rst_n) |-> empty)
        else $error("result shown right after reset");

    // A waiting result holds until taken
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(spi_word) && $stable(frame_end)))
        else $error("waiting result changed before pop");

    // Word bytes are always SPI code bytes
    a_codes: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> all_codes)
        else $error("spi_word holds a byte that is not a code byte");

    // Frame end falls exactly on word 3*count
    a_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
        (out_take && frame_end) |-> ((word_cnt_reg + 5'd1) == frame_len))
        else $error("frame_end on the wrong word");

    // No frame runs past 3*count words
    a_frame_len: assert property (@(posedge clk) disable iff (!rst_n)
        (out_take && !frame_end) |-> ((word_cnt_reg + 5'd1) < frame_len))
        else $error("frame longer than configured");

endmodule

bind led_color_store_spi_encoder_core lcse_checker u_lcse_checker (.*);

`default_nettype wire

/* sim/tb.sv */
`timescale 1ns / 1ps
// ============================================================================
// tb: testbench for led_color_store_spi_encoder_core
// Pushes LED color writes under a range of LED counts (zero, in range and
// saturating) with random push/pop idling, predicts every SPI word of each
// emitted frame from its own color store copy and checks the popped words
// in order. The count register is written and read back between phases.
// ============================================================================
module tb;
    import lcse_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 40;
    localparam int PHASE_ITEMS    = 36;
    localparam int NUM_PHASES     = 12;

    // LED count per random phase, phase 0 in the low nibble
    localparam logic [NUM_PHASES*COUNT_W-1:0] PHASE_COUNTS =
        {4'd6, 4'd4, 4'd9, 4'd7, 4'd2, 4'd8, 4'd3, 4'd15, 4'd5, 4'd0, 4'd1, 4'd8};

    localparam logic [ADDR_W-1:0] LED_COUNT_ADDR = ADDR_W'(4 * int'(REG_LED_COUNT));

    typedef struct packed {
        logic [IDX_W-1:0] index;
        logic [7:0]       green;
        logic [7:0]       red;
        logic [7:0]       blue;
    } led_write_t;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              last;
    } spi_result_t;

    // Clock, reset and DUT signals
    logic                clk         = 1'b0;
    logic                rst_n       = 1'b0;
    logic                push        = 1'b0;
    logic [IDX_W-1:0]    led_index   = '0;
    logic [7:0]          green_value = '0;
    logic [7:0]          red_value   = '0;
    logic [7:0]          blue_value  = '0;
    logic                pop         = 1'b0;
    logic                psel        = 1'b0;
    logic                penable     = 1'b0;
    logic                pwrite      = 1'b0;
    logic [ADDR_W-1:0]   paddr       = '0;
    logic [DATA_W-1:0]   pwdata      = '0;
    logic                full;
    logic                empty;
    logic [WORD_W-1:0]   spi_word;
    logic                frame_end;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    // Predictor state and bookkeeping
    logic [COLOR_W-1:0]  led_colors [MAX_LED_COUNT];
    logic [COUNT_W-1:0]  led_count_reg = LED_COUNT_RESET;
    led_write_t          led_writes_q [$];
    spi_result_t         frame_words_q [$];
    led_write_t          next_write;
    spi_result_t         next_word;
    int                  send_idle_pct = 0;
    int                  recv_idle_pct = 0;
    int                  err_cnt       = 0;
    int                  stall_cycles  = 0;

    led_color_store_spi_encoder_core u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .led_index   (led_index),
        .green_value (green_value),
        .red_value   (red_value),
        .blue_value  (blue_value),
        .empty       (empty),
        .pop         (pop),
        .spi_word    (spi_word),
        .frame_end   (frame_end),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // One color byte, MSB first, as eight SPI code bytes
    function automatic logic [WORD_W-1:0] spi_code_word(input logic [7:0] color_byte);
        logic [WORD_W-1:0] word;
        word = '0;
        for (int b = 7; b >= 0; b--)
            word = {word[WORD_W-9:0], color_byte[b] ? CODE_ONE : CODE_ZERO};
        return word;
    endfunction

    // Store the color (if the index is in range) and queue the whole frame
    function automatic void apply_led_write(input led_write_t item);
        int active;
        active = (led_count_reg > MAX_LED_COUNT) ? MAX_LED_COUNT : int'(led_count_reg);
        if (int'(item.index) < active)
            led_colors[item.index] = {item.green, item.red, item.blue};
        for (int led = 0; led < active; led++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                frame_words_q.push_back(spi_result_t'{
                    word: spi_code_word(led_colors[led][23-8*c -: 8]),
                    last: (led == active - 1) && (c == 2)});
            end
        end
    endfunction

    function automatic logic [7:0] random_color_byte();
        case ($urandom_range(9))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    // Mostly in-range indexes so the store fills; the rest hit any LED
    function automatic led_write_t random_led_write(input logic [COUNT_W-1:0] count);
        int         active;
        led_write_t item;
        active = (count > MAX_LED_COUNT) ? MAX_LED_COUNT : int'(count);
        if (active != 0 && $urandom_range(99) < 80)
            item.index = IDX_W'($urandom_range(active - 1, 0));
        else
            item.index = IDX_W'($urandom_range(MAX_LED_COUNT - 1, 0));
        item.green = random_color_byte();
        item.red   = random_color_byte();
        item.blue  = random_color_byte();
        return item;
    endfunction

    // Wait until every write is taken and every word popped, then let the
    // back end finish any frame that produces no words; checked at the
    // falling edge so the driver's updates have settled
    task automatic wait_drained();
        while (led_writes_q.size() != 0 || push || frame_words_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // APB write of the LED count, then read back
    task automatic set_led_count(input logic [COUNT_W-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= LED_COUNT_ADDR;
        pwdata  <= DATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        led_count_reg = value;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== DATA_W'(value))
        begin
            $display("%0t: led_count readback expected %h actual %h",
                     $time, DATA_W'(value), prdata);
            err_cnt++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Driver: predict on acceptance, then present the next pending write
    always @(posedge clk)
    begin
        if (!rst_n)
            push <= 1'b0;
        else
        begin
            if (push && !full)
                apply_led_write(led_write_t'{index: led_index, green: green_value,
                                             red: red_value, blue: blue_value});
            if (!push || !full)
            begin
                if (led_writes_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    next_write = led_writes_q.pop_front();
                    led_index   <= next_write.index;
                    green_value <= next_write.green;
                    red_value   <= next_write.red;
                    blue_value  <= next_write.blue;
                    push        <= 1'b1;
                end
                else
                    push <= 1'b0;
            end
        end
    end

    // Monitor: check each popped word against the oldest prediction
    always @(posedge clk)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else
        begin
            if (pop && !empty)
            begin
                if (frame_words_q.size() == 0)
                begin
                    $display("%0t: unexpected word, expected none, actual %h frame_end %b",
                             $time, spi_word, frame_end);
                    err_cnt++;
                end
                else
                begin
                    next_word = frame_words_q.pop_front();
                    if (spi_word !== next_word.word)
                    begin
                        $display("%0t: spi_word expected %h actual %h",
                                 $time, next_word.word, spi_word);
                        err_cnt++;
                    end
                    if (frame_end !== next_word.last)
                    begin
                        $display("%0t: frame_end expected %b actual %b",
                                 $time, next_word.last, frame_end);
                        err_cnt++;
                    end
                end
            end
            pop <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog: no transaction on any port for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty) || psel)
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= WATCHDOG_LIMIT)
            begin
                $display("tb failed");
                $finish;
            end
        end
    end

    // Stimulus
    initial
    begin
        logic [COUNT_W-1:0] count;
        int                 n_items;
        foreach (led_colors[i])
            led_colors[i] = '0;
        send_idle_pct = 14;
        recv_idle_pct = 63;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Reset count of eight: field extremes and alternating bit patterns
        led_writes_q.push_back(led_write_t'{3'd0, 8'hFF, 8'hFF, 8'hFF});
        led_writes_q.push_back(led_write_t'{3'd7, 8'h00, 8'h00, 8'h00});
        led_writes_q.push_back(led_write_t'{3'd7, 8'hFF, 8'h00, 8'hFF});
        led_writes_q.push_back(led_write_t'{3'd3, 8'hAA, 8'h55, 8'hAA});
        led_writes_q.push_back(led_write_t'{3'd4, 8'h55, 8'hAA, 8'h01});
        led_writes_q.push_back(led_write_t'{3'd1, 8'h80, 8'h7F, 8'hFE});
        wait_drained();

        // Short chain: writes at or above the count are dropped
        set_led_count(4'd3);
        led_writes_q.push_back(led_write_t'{3'd2, 8'h12, 8'h34, 8'h56});
        led_writes_q.push_back(led_write_t'{3'd5, 8'hFF, 8'hFF, 8'hFF});
        led_writes_q.push_back(led_write_t'{3'd3, 8'h0F, 8'hF0, 8'h3C});
        wait_drained();

        // Counts above the store size act as eight
        set_led_count(4'd15);
        led_writes_q.push_back(led_write_t'{3'd7, 8'hC3, 8'h3C, 8'h81});
        wait_drained();
        set_led_count(4'd9);
        led_writes_q.push_back(led_write_t'{3'd6, 8'h01, 8'h02, 8'h04});
        wait_drained();

        // Zero count: nothing stored, no words
        set_led_count(4'd0);
        led_writes_q.push_back(led_write_t'{3'd0, 8'hFF, 8'hFF, 8'hFF});
        led_writes_q.push_back(led_write_t'{3'd4, 8'hAA, 8'hAA, 8'hAA});
        wait_drained();

        // Single LED
        set_led_count(4'd1);
        led_writes_q.push_back(led_write_t'{3'd0, 8'h9A, 8'hBC, 8'hDE});
        led_writes_q.push_back(led_write_t'{3'd1, 8'hFF, 8'hFF, 8'hFF});
        wait_drained();

        // Random phases; sender holds off mid-phase until the frames drain
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            if (p == 4)
            begin
                send_idle_pct = 63;
                recv_idle_pct = 14;
            end
            else if (p == 8)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            count   = PHASE_COUNTS[COUNT_W*p +: COUNT_W];
            n_items = (count == 0) ? 6 : PHASE_ITEMS;
            set_led_count(count);
            for (int k = 0; k < n_items; k++)
            begin
                led_writes_q.push_back(random_led_write(count));
                if (k == n_items / 2)
                    wait_drained();
            end
            wait_drained();
        end

        if (err_cnt == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule

/* files.f */
rtl/core/lcse_pkg.sv
rtl/core/lcse_front.sv
rtl/core/lcse_back.sv
rtl/core/led_color_store_spi_encoder_core.sv
rtl/core/lcse_checker.sv
sim/tb.sv
